// ===== rtl/core/aarm_pkg.sv =====
`timescale 1ns / 1ps
package aarm_pkg;

    localparam int FRAC_BITS      = 14;
    localparam int OUT_W          = FRAC_BITS + 2;
    localparam int TRIG_STEPS_DEF = 16;
    localparam int CW             = 34;
    localparam int NUM_W          = 64;
    localparam int MAG_W          = 63;
    localparam int QB             = 34;
    localparam int DIV_W          = 32;
    localparam int ROOT_W         = 32;
    localparam int NLANE          = 9;

    localparam logic [32:0]          RAD_SCALE   = 33'd4797524520;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CW-1:0] Q30_ONE     = 34'sd1073741824;

    typedef struct packed {
        logic signed [17:0] angle_deg;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] m00;
        logic signed [OUT_W-1:0] m01;
        logic signed [OUT_W-1:0] m02;
        logic signed [OUT_W-1:0] m10;
        logic signed [OUT_W-1:0] m11;
        logic signed [OUT_W-1:0] m12;
        logic signed [OUT_W-1:0] m20;
        logic signed [OUT_W-1:0] m21;
        logic signed [OUT_W-1:0] m22;
        logic                    zero_axis;
    } t_out_item;

    function automatic logic signed [CW-1:0] atan_q30(input int idx);
        logic signed [CW-1:0] v;
        case (idx)
            0:  v = 34'sd843314856;
            1:  v = 34'sd497837829;
            2:  v = 34'sd263043836;
            3:  v = 34'sd133525158;
            4:  v = 34'sd67021686;
            5:  v = 34'sd33543515;
            6:  v = 34'sd16775850;
            7:  v = 34'sd8388437;
            8:  v = 34'sd4194282;
            9:  v = 34'sd2097149;
            10: v = 34'sd1048575;
            11: v = 34'sd524287;
            12: v = 34'sd262143;
            13: v = 34'sd131071;
            14: v = 34'sd65535;
            15: v = 34'sd32767;
            16: v = 34'sd16383;
            17: v = 34'sd8191;
            18: v = 34'sd4095;
            19: v = 34'sd2047;
            20: v = 34'sd1023;
            21: v = 34'sd511;
            22: v = 34'sd255;
            23: v = 34'sd127;
            24: v = 34'sd63;
            25: v = 34'sd31;
            26: v = 34'sd15;
            27: v = 34'sd7;
            28: v = 34'sd3;
            29: v = 34'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/aarm_isqrt.sv =====
`timescale 1ns / 1ps
module aarm_isqrt #(
    parameter int TAG_W = 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic [2*aarm_pkg::ROOT_W-1:0]    i_n,
    input  logic [TAG_W-1:0]                 i_tag,
    output logic                             o_valid,
    output logic [aarm_pkg::ROOT_W-1:0]      o_root,
    output logic [TAG_W-1:0]                 o_tag
);
    import aarm_pkg::*;

    localparam int NW = 2 * ROOT_W;

    logic [ROOT_W-1:0] r_v;
    logic [NW-1:0]     r_n   [ROOT_W];
    logic [NW-1:0]     r_r   [ROOT_W];
    logic [TAG_W-1:0]  r_tag [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_st
        localparam logic [NW-1:0] BIT = NW'(1) << (2 * (ROOT_W - 1 - k));
        logic             p_v;
        logic [NW-1:0]    p_n, p_r, n_n, n_r, t;
        logic [TAG_W-1:0] p_tag;

        if (k == 0) begin : g_first
            assign p_v   = i_valid;
            assign p_n   = i_n;
            assign p_r   = '0;
            assign p_tag = i_tag;
        end else begin : g_next
            assign p_v   = r_v[k-1];
            assign p_n   = r_n[k-1];
            assign p_r   = r_r[k-1];
            assign p_tag = r_tag[k-1];
        end

        assign t = p_r + BIT;

        always_comb begin
            if (p_n >= t) begin
                n_n = p_n - t;
                n_r = (p_r >> 1) + BIT;
            end else begin
                n_n = p_n;
                n_r = p_r >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[k]   <= n_n;
                r_r[k]   <= n_r;
                r_tag[k] <= p_tag;
            end
        end
    end

    assign o_valid = r_v[ROOT_W-1];
    assign o_root  = r_r[ROOT_W-1][ROOT_W-1:0];
    assign o_tag   = r_tag[ROOT_W-1];

endmodule

// ===== rtl/core/aarm_cordic.sv =====
`timescale 1ns / 1ps
module aarm_cordic #(
    parameter int STEPS = aarm_pkg::TRIG_STEPS_DEF,
    parameter int TAG_W = 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic signed [aarm_pkg::CW-1:0] i_z,
    input  logic [TAG_W-1:0]               i_tag,
    output logic                           o_valid,
    output logic signed [aarm_pkg::CW-1:0] o_x,
    output logic signed [aarm_pkg::CW-1:0] o_y,
    output logic [TAG_W-1:0]               o_tag
);
    import aarm_pkg::*;

    logic [STEPS-1:0]     r_v;
    logic signed [CW-1:0] r_x   [STEPS];
    logic signed [CW-1:0] r_y   [STEPS];
    logic signed [CW-1:0] r_z   [STEPS];
    logic [TAG_W-1:0]     r_tag [STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_st
        logic                 p_v;
        logic signed [CW-1:0] p_x, p_y, p_z, n_x, n_y, n_z;
        logic [TAG_W-1:0]     p_tag;

        if (k == 0) begin : g_first
            assign p_v   = i_valid;
            assign p_x   = CORDIC_GAIN;
            assign p_y   = '0;
            assign p_z   = i_z;
            assign p_tag = i_tag;
        end else begin : g_next
            assign p_v   = r_v[k-1];
            assign p_x   = r_x[k-1];
            assign p_y   = r_y[k-1];
            assign p_z   = r_z[k-1];
            assign p_tag = r_tag[k-1];
        end

        always_comb begin
            if (!p_z[CW-1]) begin
                n_x = p_x - (p_y >>> k);
                n_y = p_y + (p_x >>> k);
                n_z = p_z - atan_q30(k);
            end else begin
                n_x = p_x + (p_y >>> k);
                n_y = p_y - (p_x >>> k);
                n_z = p_z + atan_q30(k);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]   <= n_x;
                r_y[k]   <= n_y;
                r_z[k]   <= n_z;
                r_tag[k] <= p_tag;
            end
        end
    end

    assign o_valid = r_v[STEPS-1];
    assign o_x     = r_x[STEPS-1];
    assign o_y     = r_y[STEPS-1];
    assign o_tag   = r_tag[STEPS-1];

endmodule

// ===== rtl/core/aarm_div.sv =====
`timescale 1ns / 1ps
module aarm_div #(
    parameter int TAG_W = 1
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_en,
    input  logic                                            i_valid,
    input  logic [aarm_pkg::NLANE-1:0][aarm_pkg::MAG_W-1:0] i_mag,
    input  logic [aarm_pkg::NLANE-1:0][aarm_pkg::DIV_W-1:0] i_div,
    input  logic [aarm_pkg::NLANE-1:0]                      i_neg,
    input  logic [TAG_W-1:0]                                i_tag,
    output logic                                            o_valid,
    output logic [aarm_pkg::NLANE-1:0][aarm_pkg::QB-1:0]    o_quo,
    output logic [aarm_pkg::NLANE-1:0]                      o_neg,
    output logic [TAG_W-1:0]                                o_tag
);
    import aarm_pkg::*;

    localparam int CMP_W = DIV_W + QB;

    logic [QB-1:0]                  r_v;
    logic [NLANE-1:0][MAG_W-1:0]    r_rem [QB];
    logic [NLANE-1:0][QB-1:0]       r_quo [QB];
    logic [NLANE-1:0][DIV_W-1:0]    r_div [QB];
    logic [NLANE-1:0]               r_neg [QB];
    logic [TAG_W-1:0]               r_tag [QB];

    for (genvar k = 0; k < QB; k++) begin : g_st
        localparam int SH = QB - 1 - k;
        logic                        p_v;
        logic [NLANE-1:0][MAG_W-1:0] p_rem, n_rem;
        logic [NLANE-1:0][QB-1:0]    p_quo, n_quo;
        logic [NLANE-1:0][DIV_W-1:0] p_div;
        logic [NLANE-1:0][CMP_W-1:0] dsh;
        logic [NLANE-1:0]            p_neg;
        logic [TAG_W-1:0]            p_tag;

        if (k == 0) begin : g_first
            assign p_v   = i_valid;
            assign p_rem = i_mag;
            assign p_quo = '0;
            assign p_div = i_div;
            assign p_neg = i_neg;
            assign p_tag = i_tag;
        end else begin : g_next
            assign p_v   = r_v[k-1];
            assign p_rem = r_rem[k-1];
            assign p_quo = r_quo[k-1];
            assign p_div = r_div[k-1];
            assign p_neg = r_neg[k-1];
            assign p_tag = r_tag[k-1];
        end

        always_comb begin
            for (int l = 0; l < NLANE; l++) begin
                dsh[l] = CMP_W'(p_div[l]) << SH;
                if (CMP_W'(p_rem[l]) >= dsh[l]) begin
                    n_rem[l] = p_rem[l] - dsh[l][MAG_W-1:0];
                    n_quo[l] = {p_quo[l][QB-2:0], 1'b1};
                end else begin
                    n_rem[l] = p_rem[l];
                    n_quo[l] = {p_quo[l][QB-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_quo[k] <= n_quo;
                r_div[k] <= p_div;
                r_neg[k] <= p_neg;
                r_tag[k] <= p_tag;
            end
        end
    end

    assign o_valid = r_v[QB-1];
    assign o_quo   = r_quo[QB-1];
    assign o_neg   = r_neg[QB-1];
    assign o_tag   = r_tag[QB-1];

endmodule

// ===== rtl/core/axis_angle_rotation_matrix.sv =====
`timescale 1ns / 1ps
// Rotation matrix from angle and axis: a fully pipelined datapath that accepts one item per
// cycle while the output is not stalled. The pipeline holds the 32-stage square root of the
// squared axis length, one stage per CORDIC step and the 34-stage divider array that
// normalises every entry; the remaining stages reduce the angle, form the products and
// round. The whole pipeline advances while the output register is empty or being taken,
// so a stall holds every item in place. A zero axis gives the identity with zero_axis set.
module axis_angle_rotation_matrix #(
    parameter int TRIG_STEPS = aarm_pkg::TRIG_STEPS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_valid,
    output logic                o_s_ready,
    input  aarm_pkg::t_in_item  i_s_data,
    output logic                o_m_valid,
    input  logic                i_m_ready,
    output aarm_pkg::t_out_item o_m_data
);
    import aarm_pkg::*;

    localparam logic signed [18:0] FT  = 19'sd92160;
    localparam logic signed [18:0] FT2 = 19'sd184320;
    localparam logic [16:0] QT1 = 17'd23040;
    localparam logic [16:0] QT2 = 17'd46080;
    localparam logic [16:0] QT3 = 17'd69120;
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;
    localparam int LN_D0 = 0;
    localparam int LN_D1 = 1;
    localparam int LN_D2 = 2;
    localparam int LN_UV = 3;
    localparam int LN_UW = 4;
    localparam int LN_VW = 5;
    localparam int LN_BU = 6;
    localparam int LN_BV = 7;
    localparam int LN_BW = 8;
    localparam int EW = QB + 2;
    localparam int SH = 30 - FRAC_BITS;
    localparam logic signed [EW-1:0]    LIM  = EW'(2 ** FRAC_BITS);
    localparam logic signed [EW-1:0]    HALF = EW'(2 ** (SH - 1));
    localparam logic signed [OUT_W-1:0] ONE  = OUT_W'(2 ** FRAC_BITS);

    typedef struct packed {
        logic [1:0]           q;
        logic signed [CW-1:0] z;
        logic signed [15:0]   u;
        logic signed [15:0]   v;
        logic signed [15:0]   w;
        logic [30:0]          uu;
        logic [30:0]          vv;
        logic [30:0]          ww;
        logic [31:0]          l;
        logic                 zero;
    } t_sq_tag;

    typedef struct packed {
        logic [1:0]         q;
        logic signed [15:0] u;
        logic signed [15:0] v;
        logic signed [15:0] w;
        logic [30:0]        uu;
        logic [30:0]        vv;
        logic [30:0]        ww;
        logic [31:0]        l;
        logic [ROOT_W-1:0]  r;
        logic               zero;
    } t_cd_tag;

    function automatic logic signed [OUT_W-1:0] to_out(input logic signed [EW-1:0] e);
        logic signed [EW-1:0] t;
        logic signed [EW-1:0] s;
        t = e + HALF;
        s = t >>> SH;
        if (s > LIM) begin
            s = LIM;
        end else if (s < -LIM) begin
            s = -LIM;
        end
        return s[OUT_W-1:0];
    endfunction

    logic en;
    logic r_out_v;

    assign en        = !r_out_v || i_m_ready;
    assign o_s_ready = en;

    // angle reduction and axis squares
    logic               r_s1_v;
    logic [16:0]        r_s1_a;
    logic signed [15:0] r_s1_u, r_s1_v_ax, r_s1_w;
    logic [30:0]        r_s1_uu, r_s1_vv, r_s1_ww;
    logic               r_s1_zero;
    logic signed [18:0] a_ext, a_adj;
    logic signed [31:0] p_uu, p_vv, p_ww;

    always_comb begin
        a_ext = {i_s_data.angle_deg[17], i_s_data.angle_deg};
        if (a_ext < -FT) begin
            a_adj = a_ext + FT2;
        end else if (a_ext < 19'sd0) begin
            a_adj = a_ext + FT;
        end else if (a_ext >= FT) begin
            a_adj = a_ext - FT;
        end else begin
            a_adj = a_ext;
        end
    end

    assign p_uu = i_s_data.axis_x * i_s_data.axis_x;
    assign p_vv = i_s_data.axis_y * i_s_data.axis_y;
    assign p_ww = i_s_data.axis_z * i_s_data.axis_z;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_a    <= a_adj[16:0];
            r_s1_u    <= i_s_data.axis_x;
            r_s1_v_ax <= i_s_data.axis_y;
            r_s1_w    <= i_s_data.axis_z;
            r_s1_uu   <= p_uu[30:0];
            r_s1_vv   <= p_vv[30:0];
            r_s1_ww   <= p_ww[30:0];
            r_s1_zero <= (i_s_data.axis_x == '0) && (i_s_data.axis_y == '0)
                         && (i_s_data.axis_z == '0);
        end
    end

    // quadrant split and squared length
    logic               r_s2_v;
    logic [1:0]         r_s2_q, n_s2_q;
    logic [14:0]        r_s2_r;
    logic [16:0]        n_s2_d;
    logic [31:0]        r_s2_l;
    logic signed [15:0] r_s2_u, r_s2_v_ax, r_s2_w;
    logic [30:0]        r_s2_uu, r_s2_vv, r_s2_ww;
    logic               r_s2_zero;

    always_comb begin
        if (r_s1_a >= QT3) begin
            n_s2_q = QUAD_3;
            n_s2_d = r_s1_a - QT3;
        end else if (r_s1_a >= QT2) begin
            n_s2_q = QUAD_2;
            n_s2_d = r_s1_a - QT2;
        end else if (r_s1_a >= QT1) begin
            n_s2_q = QUAD_1;
            n_s2_d = r_s1_a - QT1;
        end else begin
            n_s2_q = QUAD_0;
            n_s2_d = r_s1_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_q    <= n_s2_q;
            r_s2_r    <= n_s2_d[14:0];
            r_s2_l    <= 32'(r_s1_uu) + 32'(r_s1_vv) + 32'(r_s1_ww);
            r_s2_u    <= r_s1_u;
            r_s2_v_ax <= r_s1_v_ax;
            r_s2_w    <= r_s1_w;
            r_s2_uu   <= r_s1_uu;
            r_s2_vv   <= r_s1_vv;
            r_s2_ww   <= r_s1_ww;
            r_s2_zero <= r_s1_zero;
        end
    end

    // radians in Q2.30
    logic               r_s3_v;
    logic [47:0]        n_s3_prod;
    t_sq_tag            r_s3_tag;

    assign n_s3_prod = 48'(r_s2_r) * 48'(RAD_SCALE);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_tag <= '{q: r_s2_q, z: {2'b00, n_s3_prod[47:16]}, u: r_s2_u, v: r_s2_v_ax,
                          w: r_s2_w, uu: r_s2_uu, vv: r_s2_vv, ww: r_s2_ww, l: r_s2_l,
                          zero: r_s2_zero};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
        end else if (en) begin
            r_s1_v  <= i_s_valid;
            r_s2_v  <= r_s1_v;
            r_s3_v  <= r_s2_v;
        end
    end

    // root of the squared length in Q16
    logic                      sq_v;
    logic [ROOT_W-1:0]         sq_root;
    logic [$bits(t_sq_tag)-1:0] sq_tag_vec;
    t_sq_tag                   sq_tag;

    aarm_isqrt #(
        .TAG_W ($bits(t_sq_tag))
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s3_v),
        .i_n     ({r_s3_tag.l, 32'd0}),
        .i_tag   (r_s3_tag),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_tag   (sq_tag_vec)
    );

    assign sq_tag = t_sq_tag'(sq_tag_vec);

    // sine and cosine of the remainder
    logic                       cd_v;
    logic signed [CW-1:0]       cd_x, cd_y;
    logic [$bits(t_cd_tag)-1:0] cd_tag_vec;
    t_cd_tag                    cd_tag_in, cd_tag;

    assign cd_tag_in = '{q: sq_tag.q, u: sq_tag.u, v: sq_tag.v, w: sq_tag.w, uu: sq_tag.uu,
                         vv: sq_tag.vv, ww: sq_tag.ww, l: sq_tag.l, r: sq_root,
                         zero: sq_tag.zero};

    aarm_cordic #(
        .STEPS (TRIG_STEPS),
        .TAG_W ($bits(t_cd_tag))
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_v),
        .i_z     (sq_tag.z),
        .i_tag   (cd_tag_in),
        .o_valid (cd_v),
        .o_x     (cd_x),
        .o_y     (cd_y),
        .o_tag   (cd_tag_vec)
    );

    assign cd_tag = t_cd_tag'(cd_tag_vec);

    // quadrant map
    logic                 r_q_v;
    logic signed [CW-1:0] n_q_c, n_q_s, r_q_c, r_q_s, r_q_nc;
    t_cd_tag              r_q_tag;

    always_comb begin
        case (cd_tag.q)
            QUAD_1: begin
                n_q_c = -cd_y;
                n_q_s = cd_x;
            end
            QUAD_2: begin
                n_q_c = -cd_x;
                n_q_s = -cd_y;
            end
            QUAD_3: begin
                n_q_c = cd_y;
                n_q_s = -cd_x;
            end
            default: begin
                n_q_c = cd_x;
                n_q_s = cd_y;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q_c   <= n_q_c;
            r_q_s   <= n_q_s;
            r_q_nc  <= Q30_ONE - n_q_c;
            r_q_tag <= cd_tag;
        end
    end

    // pair sums and first products
    logic                 r_m1_v;
    logic [31:0]          r_m1_svw, r_m1_suw, r_m1_suv;
    logic signed [31:0]   r_m1_uv, r_m1_uw, r_m1_vw;
    logic signed [49:0]   r_m1_us, r_m1_vs, r_m1_ws;
    logic signed [CW-1:0] r_m1_c, r_m1_nc;
    logic [30:0]          r_m1_uu, r_m1_vv, r_m1_ww;
    logic [31:0]          r_m1_l;
    logic [ROOT_W-1:0]    r_m1_r;
    logic                 r_m1_zero;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1_svw  <= 32'(r_q_tag.vv) + 32'(r_q_tag.ww);
            r_m1_suw  <= 32'(r_q_tag.uu) + 32'(r_q_tag.ww);
            r_m1_suv  <= 32'(r_q_tag.uu) + 32'(r_q_tag.vv);
            r_m1_uv   <= r_q_tag.u * r_q_tag.v;
            r_m1_uw   <= r_q_tag.u * r_q_tag.w;
            r_m1_vw   <= r_q_tag.v * r_q_tag.w;
            r_m1_us   <= r_q_tag.u * r_q_s;
            r_m1_vs   <= r_q_tag.v * r_q_s;
            r_m1_ws   <= r_q_tag.w * r_q_s;
            r_m1_c    <= r_q_c;
            r_m1_nc   <= r_q_nc;
            r_m1_uu   <= r_q_tag.uu;
            r_m1_vv   <= r_q_tag.vv;
            r_m1_ww   <= r_q_tag.ww;
            r_m1_l    <= r_q_tag.l;
            r_m1_r    <= r_q_tag.r;
            r_m1_zero <= r_q_tag.zero;
        end
    end

    // second products
    logic                    r_m2_v;
    logic signed [NUM_W-1:0] r_m2_p [NLANE];
    logic [30:0]             r_m2_uu, r_m2_vv, r_m2_ww;
    logic [31:0]             r_m2_l;
    logic [ROOT_W-1:0]       r_m2_r;
    logic                    r_m2_zero;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m2_p[LN_D0] <= $signed({1'b0, r_m1_svw}) * r_m1_c;
            r_m2_p[LN_D1] <= $signed({1'b0, r_m1_suw}) * r_m1_c;
            r_m2_p[LN_D2] <= $signed({1'b0, r_m1_suv}) * r_m1_c;
            r_m2_p[LN_UV] <= r_m1_uv * r_m1_nc;
            r_m2_p[LN_UW] <= r_m1_uw * r_m1_nc;
            r_m2_p[LN_VW] <= r_m1_vw * r_m1_nc;
            r_m2_p[LN_BU] <= NUM_W'(r_m1_us) <<< 16;
            r_m2_p[LN_BV] <= NUM_W'(r_m1_vs) <<< 16;
            r_m2_p[LN_BW] <= NUM_W'(r_m1_ws) <<< 16;
            r_m2_uu       <= r_m1_uu;
            r_m2_vv       <= r_m1_vv;
            r_m2_ww       <= r_m1_ww;
            r_m2_l        <= r_m1_l;
            r_m2_r        <= r_m1_r;
            r_m2_zero     <= r_m1_zero;
        end
    end

    // numerators
    logic                    r_m3_v;
    logic signed [NUM_W-1:0] r_m3_num [NLANE];
    logic [31:0]             r_m3_l;
    logic [ROOT_W-1:0]       r_m3_r;
    logic                    r_m3_zero;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m3_num[LN_D0] <= $signed({3'b000, r_m2_uu, 30'd0}) + r_m2_p[LN_D0];
            r_m3_num[LN_D1] <= $signed({3'b000, r_m2_vv, 30'd0}) + r_m2_p[LN_D1];
            r_m3_num[LN_D2] <= $signed({3'b000, r_m2_ww, 30'd0}) + r_m2_p[LN_D2];
            for (int l = LN_UV; l < NLANE; l++) begin
                r_m3_num[l] <= r_m2_p[l];
            end
            r_m3_l    <= r_m2_l;
            r_m3_r    <= r_m2_r;
            r_m3_zero <= r_m2_zero;
        end
    end

    // magnitudes, signs and divisors
    logic                        r_m4_v;
    logic [NLANE-1:0][MAG_W-1:0] r_m4_mag;
    logic [NLANE-1:0][DIV_W-1:0] r_m4_div;
    logic [NLANE-1:0]            r_m4_neg;
    logic                        r_m4_zero;
    logic signed [NUM_W-1:0]     abs_num [NLANE];

    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            abs_num[l] = r_m3_num[l][NUM_W-1] ? -r_m3_num[l] : r_m3_num[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < NLANE; l++) begin
                r_m4_mag[l] <= abs_num[l][MAG_W-1:0];
                r_m4_neg[l] <= r_m3_num[l][NUM_W-1];
                r_m4_div[l] <= (l < LN_BU) ? r_m3_l : DIV_W'(r_m3_r);
            end
            r_m4_zero <= r_m3_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_v  <= 1'b0;
            r_m1_v <= 1'b0;
            r_m2_v <= 1'b0;
            r_m3_v <= 1'b0;
            r_m4_v <= 1'b0;
        end else if (en) begin
            r_q_v  <= cd_v;
            r_m1_v <= r_q_v;
            r_m2_v <= r_m1_v;
            r_m3_v <= r_m2_v;
            r_m4_v <= r_m3_v;
        end
    end

    // normalising divisions
    logic                     dv_v;
    logic [NLANE-1:0][QB-1:0] dv_quo;
    logic [NLANE-1:0]         dv_neg;
    logic                     dv_zero;

    aarm_div #(
        .TAG_W (1)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_m4_v),
        .i_mag   (r_m4_mag),
        .i_div   (r_m4_div),
        .i_neg   (r_m4_neg),
        .i_tag   (r_m4_zero),
        .o_valid (dv_v),
        .o_quo   (dv_quo),
        .o_neg   (dv_neg),
        .o_tag   (dv_zero)
    );

    // signed quotients
    logic                 r_p1_v;
    logic signed [QB:0]   r_p1_q [NLANE];
    logic                 r_p1_zero;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < NLANE; l++) begin
                r_p1_q[l] <= dv_neg[l] ? -$signed({1'b0, dv_quo[l]}) : $signed({1'b0, dv_quo[l]});
            end
            r_p1_zero <= dv_zero;
        end
    end

    // entries in Q30
    logic                 r_p2_v;
    logic signed [EW-1:0] r_p2_e [NLANE];
    logic                 r_p2_zero;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p2_e[0] <= EW'(r_p1_q[LN_D0]);
            r_p2_e[1] <= EW'(r_p1_q[LN_UV]) - EW'(r_p1_q[LN_BW]);
            r_p2_e[2] <= EW'(r_p1_q[LN_UW]) + EW'(r_p1_q[LN_BV]);
            r_p2_e[3] <= EW'(r_p1_q[LN_UV]) + EW'(r_p1_q[LN_BW]);
            r_p2_e[4] <= EW'(r_p1_q[LN_D1]);
            r_p2_e[5] <= EW'(r_p1_q[LN_VW]) - EW'(r_p1_q[LN_BU]);
            r_p2_e[6] <= EW'(r_p1_q[LN_UW]) - EW'(r_p1_q[LN_BV]);
            r_p2_e[7] <= EW'(r_p1_q[LN_VW]) + EW'(r_p1_q[LN_BU]);
            r_p2_e[8] <= EW'(r_p1_q[LN_D2]);
            r_p2_zero <= r_p1_zero;
        end
    end

    // round, saturate, hold for the consumer
    t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_p2_zero) begin
                r_out <= '{m00: ONE, m01: '0, m02: '0, m10: '0, m11: ONE, m12: '0,
                           m20: '0, m21: '0, m22: ONE, zero_axis: 1'b1};
            end else begin
                r_out <= '{m00: to_out(r_p2_e[0]), m01: to_out(r_p2_e[1]),
                           m02: to_out(r_p2_e[2]), m10: to_out(r_p2_e[3]),
                           m11: to_out(r_p2_e[4]), m12: to_out(r_p2_e[5]),
                           m20: to_out(r_p2_e[6]), m21: to_out(r_p2_e[7]),
                           m22: to_out(r_p2_e[8]), zero_axis: 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v  <= 1'b0;
            r_p2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_p1_v  <= dv_v;
            r_p2_v  <= r_p1_v;
            r_out_v <= r_p2_v;
        end
    end

    assign o_m_valid = r_out_v;
    assign o_m_data  = r_out;

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_valid)
        else $error("result valid straight after reset");

    a_zero_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_valid && o_m_data.zero_axis |->
            o_m_data.m00 == ONE && o_m_data.m11 == ONE && o_m_data.m22 == ONE &&
            o_m_data.m01 == '0 && o_m_data.m02 == '0 && o_m_data.m10 == '0 &&
            o_m_data.m12 == '0 && o_m_data.m20 == '0 && o_m_data.m21 == '0)
        else $error("zero axis item is not the identity");

    a_diag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_valid |->
            o_m_data.m00 <= ONE && o_m_data.m00 >= -ONE &&
            o_m_data.m11 <= ONE && o_m_data.m11 >= -ONE &&
            o_m_data.m22 <= ONE && o_m_data.m22 >= -ONE)
        else $error("diagonal entry outside saturation range");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import aarm_pkg::*;

    localparam int LATENCY     = 77 + TRIG_STEPS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM    = 550;

    localparam int PH_FREE    = 0;
    localparam int PH_SRC     = 1;
    localparam int PH_SNK     = 2;
    localparam int PH_BOTH    = 3;
    localparam int PH_HOLDOFF = 4;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    t_in_item  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    t_out_item m_data;
    logic      s_ready_seen = 1'b0;

    axis_angle_rotation_matrix dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_valid),
        .o_s_ready (s_ready),
        .i_s_data  (s_data),
        .o_m_valid (m_valid),
        .i_m_ready (m_ready),
        .o_m_data  (m_data)
    );

    always #5 i_clk = ~i_clk;

    t_in_item  pending_items[$];
    t_out_item expected_matrices[$];
    int        phase = PH_FREE;
    int        holdoff_left = 0;
    int        mismatches = 0;
    int        cycles = 0;
    int        accepted = 0;
    int        zero_axis_seen = 0;
    longint    atan_q30_tab[32] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
        131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
        127, 63, 31, 15, 7, 3, 1, 0, 0
    };

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > n) bit_v = bit_v >> 2;
        while (bit_v != 0) begin
            if (n >= res + bit_v) begin
                n = n - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return longint'(res);
    endfunction

    function automatic logic signed [OUT_W-1:0] round_sat(longint q30);
        longint v, lim;
        lim = longint'(1) << FRAC_BITS;
        v = (q30 + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        return v[OUT_W-1:0];
    endfunction

    function automatic t_out_item rotation_matrix(t_in_item it);
        t_out_item o;
        longint a, u, v, w, uu, vv, ww, len2, x, y, z, r, c, s, nc, root;
        longint dx, dy, uv, uw, vw, bu, bv, bw, one;
        int q;
        one = longint'(1) << 30;
        a = it.angle_deg;
        u = it.axis_x;
        v = it.axis_y;
        w = it.axis_z;
        uu = u * u;
        vv = v * v;
        ww = w * w;
        len2 = uu + vv + ww;
        o = '0;
        if (len2 == 0) begin
            o.m00 = round_sat(one);
            o.m11 = round_sat(one);
            o.m22 = round_sat(one);
            o.zero_axis = 1'b1;
            return o;
        end
        while (a < 0) a += 92160;
        while (a >= 92160) a -= 92160;
        q = int'(a / 23040);
        r = a - q * 23040;
        z = (r * 64'sd4797524520) >>> 16;
        x = 652032874;
        y = 0;
        for (int i = 0; i < TRIG_STEPS_DEF && i < 32; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_q30_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_q30_tab[i];
            end
        end
        case (q)
            1: begin c = -y; s = x; end
            2: begin c = -x; s = -y; end
            3: begin c = y; s = -x; end
            default: begin c = x; s = y; end
        endcase
        nc = one - c;
        root = int_sqrt(longint'(len2) << 32);
        uv = (u * v * nc) / len2;
        uw = (u * w * nc) / len2;
        vw = (v * w * nc) / len2;
        bu = (u * s * 65536) / root;
        bv = (v * s * 65536) / root;
        bw = (w * s * 65536) / root;
        o.m00 = round_sat((uu * one + (vv + ww) * c) / len2);
        o.m01 = round_sat(uv - bw);
        o.m02 = round_sat(uw + bv);
        o.m10 = round_sat(uv + bw);
        o.m11 = round_sat((vv * one + (uu + ww) * c) / len2);
        o.m12 = round_sat(vw - bu);
        o.m20 = round_sat(uw - bv);
        o.m21 = round_sat(vw + bu);
        o.m22 = round_sat((ww * one + (uu + vv) * c) / len2);
        o.zero_axis = 1'b0;
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
        mismatches++;
    endtask

    function automatic bit src_idle();
        if (phase == PH_SRC) return $urandom_range(99) < 53;
        if (phase == PH_BOTH) return $urandom_range(99) < 14;
        return 1'b0;
    endfunction

    function automatic bit snk_stall();
        if (phase == PH_HOLDOFF) return holdoff_left > 0;
        if (phase == PH_SNK) return $urandom_range(99) < 53;
        if (phase == PH_BOTH) return $urandom_range(99) < 14;
        return 1'b0;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!s_valid || s_ready_seen) begin
                if (pending_items.size() != 0 && !src_idle()) begin
                    s_data <= pending_items.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= !snk_stall();
        end
    end

    // hold-off counter
    always @(posedge i_clk) begin
        if (holdoff_left > 0) holdoff_left--;
    end

    // monitor
    always @(posedge i_clk) begin
        cycles++;
        s_ready_seen <= i_rst_n && s_valid && s_ready;
        if (i_rst_n) begin
            if (s_valid && s_ready) begin
                expected_matrices = {expected_matrices, rotation_matrix(s_data)};
                accepted++;
            end
            if (m_valid && m_ready) begin
                if (expected_matrices.size() == 0) begin
                    report_mismatch("unexpected item", 0, 0);
                end else begin
                    t_out_item e;
                    e = expected_matrices.pop_front();
                    if (m_data.m00 != e.m00) report_mismatch("m00", m_data.m00, e.m00);
                    if (m_data.m01 != e.m01) report_mismatch("m01", m_data.m01, e.m01);
                    if (m_data.m02 != e.m02) report_mismatch("m02", m_data.m02, e.m02);
                    if (m_data.m10 != e.m10) report_mismatch("m10", m_data.m10, e.m10);
                    if (m_data.m11 != e.m11) report_mismatch("m11", m_data.m11, e.m11);
                    if (m_data.m12 != e.m12) report_mismatch("m12", m_data.m12, e.m12);
                    if (m_data.m20 != e.m20) report_mismatch("m20", m_data.m20, e.m20);
                    if (m_data.m21 != e.m21) report_mismatch("m21", m_data.m21, e.m21);
                    if (m_data.m22 != e.m22) report_mismatch("m22", m_data.m22, e.m22);
                    if (m_data.zero_axis != e.zero_axis)
                        report_mismatch("zero_axis", m_data.zero_axis, e.zero_axis);
                    if (e.zero_axis) zero_axis_seen++;
                end
            end
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout at cycle %0d", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic t_in_item make_item(longint ang, longint ax, longint ay, longint az);
        t_in_item it;
        it.angle_deg = ang[17:0];
        it.axis_x = ax[15:0];
        it.axis_y = ay[15:0];
        it.axis_z = az[15:0];
        return it;
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        int sel;
        it = '0;
        sel = $urandom_range(9);
        if (sel < 6) it.angle_deg = 18'($signed($urandom_range(184320)) - 92160);
        else it.angle_deg = 18'($urandom());
        it.axis_x = 16'($urandom());
        it.axis_y = 16'($urandom());
        it.axis_z = 16'($urandom());
        sel = $urandom_range(19);
        if (sel == 0) begin
            it.axis_x = '0; it.axis_y = '0; it.axis_z = '0;
        end else if (sel < 4) begin
            it.axis_x = 16'($signed($urandom_range(8)) - 4);
            it.axis_y = 16'($signed($urandom_range(8)) - 4);
            it.axis_z = 16'($signed($urandom_range(8)) - 4);
        end else if (sel < 6) begin
            it.axis_y = '0;
            it.axis_z = '0;
        end else if (sel == 6) begin
            it.angle_deg = 18'(23040 * ($signed($urandom_range(8)) - 4));
        end
        return it;
    endfunction

    task automatic add_item(t_in_item it);
        pending_items = {pending_items, it};
    endtask

    task automatic add_random(int n);
        for (int i = 0; i < n; i++) add_item(random_item());
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || s_valid || expected_matrices.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        phase = PH_FREE;
        add_item(make_item(0, 0, 0, 0));
        add_item(make_item(5000, 0, 0, 0));
        add_item(make_item(0, 0, 0, 1));
        add_item(make_item(23040, 0, 0, 1));
        add_item(make_item(46080, 1, 0, 0));
        add_item(make_item(69120, 0, 1, 0));
        add_item(make_item(92160, 1, 1, 1));
        add_item(make_item(-92160, 1, 1, 1));
        add_item(make_item(-23040, 3, -4, 12));
        add_item(make_item(131071, 32767, 32767, 32767));
        add_item(make_item(-131072, -32768, -32768, -32768));
        add_item(make_item(23039, 32767, -32768, 1));
        add_item(make_item(11520, -32768, 0, 0));
        add_item(make_item(1, 0, -1, 0));
        add_item(make_item(-1, 0, 0, -32768));
        add_item(make_item(7680, 1, 32767, -1));
        add_item(make_item(-46080, -1, -1, -1));
        add_item(make_item(100000, 12345, -23456, 31000));
        wait_drained();

        phase = PH_FREE;  add_random(120); wait_drained();
        phase = PH_SRC;   add_random(110); wait_drained();
        phase = PH_SNK;   add_random(110); wait_drained();
        phase = PH_BOTH;  add_random(80);  wait_drained();

        // hold the receiver off while the sender keeps offering
        phase = PH_HOLDOFF;
        holdoff_left = 3 * LATENCY;
        add_random(110);
        wait_drained();

        repeat (LATENCY + 10) @(posedge i_clk);
        $display("covered %0d items, %0d with a zero axis, across idle, stall and hold-off phases",
                 accepted, zero_axis_seen);
        if (mismatches == 0 && expected_matrices.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/aarm_pkg.sv
rtl/core/aarm_isqrt.sv
rtl/core/aarm_cordic.sv
rtl/core/aarm_div.sv
rtl/core/axis_angle_rotation_matrix.sv
tb/tb_top.sv
